// ===== hdl/lmsr_pkg.sv =====
// Shared types, constants and helpers for the LED matrix scroll and refresh block.
// Used by lmsr_ctrl, lmsr_datapath, the top level and the checker.
`default_nettype none

package lmsr_pkg;

  localparam int unsigned MAX_CHIPS_DEF = 8;
  localparam int unsigned NUM_COLS      = 64;

  localparam logic [3:0] OP_D0          = 4'd1;
  localparam logic [3:0] OP_DECODE_SEL  = 4'd9;
  localparam logic [3:0] OP_BRIGHTNESS  = 4'd10;
  localparam logic [3:0] OP_SCAN_LIM    = 4'd11;
  localparam logic [3:0] OP_POWER_DN    = 4'd12;
  localparam logic [3:0] OP_TEST        = 4'd15;

  localparam logic [3:0]  DEV_COUNT_RST  = 4'd8;
  localparam logic [15:0] FRAME_PER_RST  = 16'd40;
  localparam logic [3:0]  BRIGHT_RST     = 4'd1;
  localparam logic [3:0]  BRIGHT_MAX     = 4'd15;
  localparam logic [3:0]  BRIGHT_MIN     = 4'd1;
  localparam logic [15:0] TICK_SAT       = 16'hFFFF;
  localparam logic [7:0]  SCAN_ALL_ROWS  = 8'd7;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_TOGGLE = 2'd1,
    CMD_LEVEL  = 2'd2,
    CMD_INIT   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    CFG_DEVICE_COUNT = 2'd0,
    CFG_FRAME_PERIOD = 2'd1,
    CFG_SCROLL_MODE  = 2'd2,
    CFG_BLINK_MODE   = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    SCROLL_NONE  = 2'd0,
    SCROLL_LEFT  = 2'd1,
    SCROLL_RIGHT = 2'd2,
    SCROLL_RSVD  = 2'd3
  } scroll_e;

  typedef enum logic [1:0] {
    BLINK_NONE  = 2'd0,
    BLINK_TOGGLE = 2'd1,
    BLINK_FADE  = 2'd2,
    BLINK_RSVD  = 2'd3
  } blink_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_INTENS,
    ST_LEVEL,
    ST_TEST,
    ST_SCAN,
    ST_DECODE,
    ST_SHUTDN,
    ST_ROWS
  } state_e;

  typedef enum logic [2:0] {
    WORD_BRIGHT,
    WORD_LEVEL,
    WORD_TEST,
    WORD_SCAN,
    WORD_DECODE,
    WORD_SHUTDOWN,
    WORD_ROW
  } word_e;

  typedef struct packed {
    logic  capture;
    logic  tick_step;
    logic  update;
    logic  toggle;
    logic  row_clr;
    logic  row_inc;
    logic  emit;
    word_e word;
    logic  last;
  } ctrl_cmd_t;

  typedef struct packed {
    cmd_e cmd;
    logic hit;
    logic blink_on;
    logic row_last;
    logic slot_free;
  } ctrl_sts_t;

  function automatic logic [63:0] bcast(input logic [7:0] b, input logic [63:0] mask);
    return {8{b}} & mask;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/led_matrix_scroll_refresh_top.sv =====
// Top level of the LED matrix scroll and refresh block.
// Depends on lmsr_pkg, lmsr_ctrl and lmsr_datapath.
//
//  channel | direction | handshake               | payload
//  in      | input     | in_valid_i / in_ready_o | cmd, pixel_x, pixel_y, level, entering_column
//  out     | output    | out_valid_o/out_ready_i | opcode, chip_data, last
//  cfg     | input     | cfg_we_i                | cfg_index_i, cfg_data_i
//
// One transaction at a time: accept, execute, then the output words in order. Toggle and a
// non-updating tick emit none; an update emits a brightness word if blinking, then the rows.
// Each word waits in the output register while out_ready_i is low.
// Reset clears the 64-column frame, tick counter and brightness (one) at once.
`default_nettype none

module led_matrix_scroll_refresh_top #(
  parameter int unsigned MAX_CHIPS = lmsr_pkg::MAX_CHIPS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  cmd_i,
  input  wire logic [5:0]  pixel_x_i,
  input  wire logic [2:0]  pixel_y_i,
  input  wire logic [3:0]  level_i,
  input  wire logic [7:0]  entering_column_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [3:0]       opcode_o,
  output logic [63:0]      chip_data_o,
  output logic             last_o
);

  lmsr_pkg::ctrl_cmd_t ctl;
  lmsr_pkg::ctrl_sts_t sts;

  lmsr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (ctl)
  );

  lmsr_datapath #(
    .MAX_CHIPS (MAX_CHIPS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .cmd_i             (cmd_i),
    .pixel_x_i         (pixel_x_i),
    .pixel_y_i         (pixel_y_i),
    .level_i           (level_i),
    .entering_column_i (entering_column_i),
    .ctl_i             (ctl),
    .sts_o             (sts),
    .out_ready_i       (out_ready_i),
    .out_valid_o       (out_valid_o),
    .opcode_o          (opcode_o),
    .chip_data_o       (chip_data_o),
    .last_o            (last_o)
  );

endmodule

`default_nettype wire

// ===== hdl/lmsr_ctrl.sv =====
// Sequencer for the LED matrix scroll and refresh block.
// Depends on lmsr_pkg; drives lmsr_datapath through ctrl_cmd_t and reads ctrl_sts_t.
`default_nettype none

module lmsr_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire lmsr_pkg::ctrl_sts_t sts_i,
  output lmsr_pkg::ctrl_cmd_t      cmd_o
);

  lmsr_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lmsr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.word = lmsr_pkg::WORD_ROW;
    unique case (state_q)
      lmsr_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = lmsr_pkg::ST_EXEC;
        end
      end
      lmsr_pkg::ST_EXEC: begin
        unique case (sts_i.cmd)
          lmsr_pkg::CMD_TICK: begin
            cmd_o.tick_step = 1'b1;
            if (sts_i.hit) begin
              cmd_o.update  = 1'b1;
              cmd_o.row_clr = 1'b1;
              state_d = sts_i.blink_on ? lmsr_pkg::ST_INTENS : lmsr_pkg::ST_ROWS;
            end else begin
              state_d = lmsr_pkg::ST_IDLE;
            end
          end
          lmsr_pkg::CMD_TOGGLE: begin
            cmd_o.toggle = 1'b1;
            state_d      = lmsr_pkg::ST_IDLE;
          end
          lmsr_pkg::CMD_LEVEL: begin
            state_d = lmsr_pkg::ST_LEVEL;
          end
          lmsr_pkg::CMD_INIT: begin
            cmd_o.row_clr = 1'b1;
            state_d       = lmsr_pkg::ST_TEST;
          end
          default: state_d = lmsr_pkg::ST_IDLE;
        endcase
      end
      lmsr_pkg::ST_INTENS: begin
        cmd_o.word = lmsr_pkg::WORD_BRIGHT;
        if (sts_i.slot_free) begin
          cmd_o.emit = 1'b1;
          state_d    = lmsr_pkg::ST_ROWS;
        end
      end
      lmsr_pkg::ST_LEVEL: begin
        cmd_o.word = lmsr_pkg::WORD_LEVEL;
        cmd_o.last = 1'b1;
        if (sts_i.slot_free) begin
          cmd_o.emit = 1'b1;
          state_d    = lmsr_pkg::ST_IDLE;
        end
      end
      lmsr_pkg::ST_TEST: begin
        cmd_o.word = lmsr_pkg::WORD_TEST;
        if (sts_i.slot_free) begin
          cmd_o.emit = 1'b1;
          state_d    = lmsr_pkg::ST_SCAN;
        end
      end
      lmsr_pkg::ST_SCAN: begin
        cmd_o.word = lmsr_pkg::WORD_SCAN;
        if (sts_i.slot_free) begin
          cmd_o.emit = 1'b1;
          state_d    = lmsr_pkg::ST_DECODE;
        end
      end
      lmsr_pkg::ST_DECODE: begin
        cmd_o.word = lmsr_pkg::WORD_DECODE;
        if (sts_i.slot_free) begin
          cmd_o.emit = 1'b1;
          state_d    = lmsr_pkg::ST_SHUTDN;
        end
      end
      lmsr_pkg::ST_SHUTDN: begin
        cmd_o.word = lmsr_pkg::WORD_SHUTDOWN;
        if (sts_i.slot_free) begin
          cmd_o.emit = 1'b1;
          state_d    = lmsr_pkg::ST_ROWS;
        end
      end
      lmsr_pkg::ST_ROWS: begin
        cmd_o.word = lmsr_pkg::WORD_ROW;
        cmd_o.last = sts_i.row_last;
        if (sts_i.slot_free) begin
          cmd_o.emit    = 1'b1;
          cmd_o.row_inc = 1'b1;
          if (sts_i.row_last) begin
            state_d = lmsr_pkg::ST_IDLE;
          end
        end
      end
      default: state_d = lmsr_pkg::ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/lmsr_datapath.sv =====
// Datapath: configuration, column frame, tick counter, brightness and output register.
// Depends on lmsr_pkg; controlled by lmsr_ctrl.
`default_nettype none

module lmsr_datapath #(
  parameter int unsigned MAX_CHIPS = lmsr_pkg::MAX_CHIPS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [1:0]          cfg_index_i,
  input  wire logic [15:0]         cfg_data_i,
  input  wire logic [1:0]          cmd_i,
  input  wire logic [5:0]          pixel_x_i,
  input  wire logic [2:0]          pixel_y_i,
  input  wire logic [3:0]          level_i,
  input  wire logic [7:0]          entering_column_i,
  input  wire lmsr_pkg::ctrl_cmd_t ctl_i,
  output lmsr_pkg::ctrl_sts_t      sts_o,
  input  wire logic                out_ready_i,
  output logic                     out_valid_o,
  output logic [3:0]               opcode_o,
  output logic [63:0]              chip_data_o,
  output logic                     last_o
);

  localparam int unsigned NumCols  = lmsr_pkg::NUM_COLS;
  localparam logic [3:0]  ChipsTop = 4'(MAX_CHIPS);

  logic [3:0]  dev_q;
  logic [15:0] period_q;
  logic [1:0]  scroll_q;
  logic [1:0]  blink_q;

  logic [1:0]  cmd_q;
  logic [5:0]  px_q;
  logic [2:0]  py_q;
  logic [3:0]  level_q;
  logic [7:0]  enter_q;

  logic [7:0]  frame_q [NumCols];
  logic [7:0]  frame_d [NumCols];
  logic [15:0] tick_q, tick_d, tick_inc, period_eff;
  logic [3:0]  bright_q, bright_d;
  logic [2:0]  row_q;

  logic [3:0]  chips;
  logic [6:0]  cols;
  logic [63:0] chip_mask;
  logic [63:0] row_bits;
  logic        hit;

  logic        out_valid_q;
  logic [3:0]  opcode_q, opcode_d;
  logic [63:0] data_q, data_d;
  logic        last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_q    <= lmsr_pkg::DEV_COUNT_RST;
      period_q <= lmsr_pkg::FRAME_PER_RST;
      scroll_q <= lmsr_pkg::SCROLL_LEFT;
      blink_q  <= lmsr_pkg::BLINK_NONE;
    end else if (cfg_we_i) begin
      unique case (lmsr_pkg::cfg_idx_e'(cfg_index_i))
        lmsr_pkg::CFG_DEVICE_COUNT: dev_q    <= cfg_data_i[3:0];
        lmsr_pkg::CFG_FRAME_PERIOD: period_q <= cfg_data_i;
        lmsr_pkg::CFG_SCROLL_MODE:  scroll_q <= cfg_data_i[1:0];
        lmsr_pkg::CFG_BLINK_MODE:   blink_q  <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      cmd_q   <= cmd_i;
      px_q    <= pixel_x_i;
      py_q    <= pixel_y_i;
      level_q <= level_i;
      enter_q <= entering_column_i;
    end
  end

  always_comb begin
    chips = dev_q;
    if (chips == 4'd0) begin
      chips = 4'd1;
    end
    if (chips > ChipsTop) begin
      chips = ChipsTop;
    end
    cols = {chips, 3'b000};
    for (int d = 0; d < 8; d++) begin
      chip_mask[8*d +: 8] = (4'(d) < chips) ? 8'hFF : 8'h00;
    end
  end

  always_comb begin
    tick_inc   = (tick_q == lmsr_pkg::TICK_SAT) ? tick_q : tick_q + 16'd1;
    period_eff = (period_q == 16'd0) ? 16'd1 : period_q;
    hit        = (tick_inc >= period_eff);
    tick_d     = tick_q;
    if (ctl_i.tick_step) begin
      tick_d = hit ? 16'd0 : tick_inc;
    end
  end

  always_comb begin
    bright_d = bright_q;
    if (ctl_i.update) begin
      unique case (lmsr_pkg::blink_e'(blink_q))
        lmsr_pkg::BLINK_TOGGLE:
          bright_d = (bright_q > lmsr_pkg::BRIGHT_MIN) ? lmsr_pkg::BRIGHT_MIN
                                                       : lmsr_pkg::BRIGHT_MAX;
        lmsr_pkg::BLINK_FADE:
          bright_d = (bright_q < lmsr_pkg::BRIGHT_MAX) ? bright_q + 4'd1
                                                       : lmsr_pkg::BRIGHT_MIN;
        default: bright_d = bright_q;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < NumCols; i++) begin
      frame_d[i] = frame_q[i];
      if (ctl_i.update) begin
        unique case (lmsr_pkg::scroll_e'(scroll_q))
          lmsr_pkg::SCROLL_LEFT: begin
            if (7'(i) == cols - 7'd1) begin
              frame_d[i] = enter_q;
            end else if (7'(i) < cols - 7'd1) begin
              frame_d[i] = frame_q[(i + 1) % NumCols];
            end
          end
          lmsr_pkg::SCROLL_RIGHT: begin
            if (i == 0) begin
              frame_d[i] = enter_q;
            end else if (7'(i) < cols) begin
              frame_d[i] = frame_q[(i + NumCols - 1) % NumCols];
            end
          end
          default: frame_d[i] = frame_q[i];
        endcase
      end
      if (ctl_i.toggle && (px_q == 6'(i))) begin
        frame_d[i] = frame_q[i] ^ (8'd1 << py_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumCols; i++) begin
        frame_q[i] <= '0;
      end
      tick_q   <= '0;
      bright_q <= lmsr_pkg::BRIGHT_RST;
      row_q    <= '0;
    end else begin
      frame_q  <= frame_d;
      tick_q   <= tick_d;
      bright_q <= bright_d;
      if (ctl_i.row_clr) begin
        row_q <= '0;
      end else if (ctl_i.row_inc) begin
        row_q <= row_q + 3'd1;
      end
    end
  end

  always_comb begin
    for (int c = 0; c < NumCols; c++) begin
      row_bits[c] = frame_q[c][3'd7 - row_q];
    end
  end

  always_comb begin
    opcode_d = lmsr_pkg::OP_D0 + {1'b0, row_q};
    data_d   = row_bits & chip_mask;
    unique case (ctl_i.word)
      lmsr_pkg::WORD_BRIGHT: begin
        opcode_d = lmsr_pkg::OP_BRIGHTNESS;
        data_d   = lmsr_pkg::bcast({4'd0, bright_q}, chip_mask);
      end
      lmsr_pkg::WORD_LEVEL: begin
        opcode_d = lmsr_pkg::OP_BRIGHTNESS;
        data_d   = lmsr_pkg::bcast({4'd0, level_q}, chip_mask);
      end
      lmsr_pkg::WORD_TEST: begin
        opcode_d = lmsr_pkg::OP_TEST;
        data_d   = '0;
      end
      lmsr_pkg::WORD_SCAN: begin
        opcode_d = lmsr_pkg::OP_SCAN_LIM;
        data_d   = lmsr_pkg::bcast(lmsr_pkg::SCAN_ALL_ROWS, chip_mask);
      end
      lmsr_pkg::WORD_DECODE: begin
        opcode_d = lmsr_pkg::OP_DECODE_SEL;
        data_d   = '0;
      end
      lmsr_pkg::WORD_SHUTDOWN: begin
        opcode_d = lmsr_pkg::OP_POWER_DN;
        data_d   = lmsr_pkg::bcast(8'd1, chip_mask);
      end
      lmsr_pkg::WORD_ROW: begin
        opcode_d = lmsr_pkg::OP_D0 + {1'b0, row_q};
        data_d   = row_bits & chip_mask;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.emit) begin
      opcode_q <= opcode_d;
      data_q   <= data_d;
      last_q   <= ctl_i.last;
    end
  end

  assign sts_o.cmd       = lmsr_pkg::cmd_e'(cmd_q);
  assign sts_o.hit       = hit;
  assign sts_o.blink_on  = (blink_q == lmsr_pkg::BLINK_TOGGLE) ||
                           (blink_q == lmsr_pkg::BLINK_FADE);
  assign sts_o.row_last  = (row_q == 3'd7);
  assign sts_o.slot_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign opcode_o    = opcode_q;
  assign chip_data_o = data_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire

// ===== hdl/lmsr_checker.sv =====
// Port-level checks for led_matrix_scroll_refresh_top, attached by bind.
// Depends on lmsr_pkg.
`default_nettype none

module lmsr_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [3:0]  opcode_o,
  input wire logic [63:0] chip_data_o,
  input wire logic        last_o
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(opcode_o) &&
      $stable(chip_data_o) && $stable(last_o))
    else $error("output transaction changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted back to back");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (opcode_o == lmsr_pkg::OP_TEST || opcode_o == lmsr_pkg::OP_DECODE_SEL)
      |-> chip_data_o == 64'd0)
    else $error("test or decode word carries nonzero data");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (opcode_o == lmsr_pkg::OP_TEST || opcode_o == lmsr_pkg::OP_SCAN_LIM ||
      opcode_o == lmsr_pkg::OP_POWER_DN) |-> !last_o)
    else $error("start-up word marked last");

endmodule

bind led_matrix_scroll_refresh_top lmsr_checker u_lmsr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .opcode_o    (opcode_o),
  .chip_data_o (chip_data_o),
  .last_o      (last_o)
);

`default_nettype wire
